[rtl/core/ffba_pkg.sv]
// Shared types and codes of the first-fit block allocator.
`default_nettype none
package ffba_pkg;

  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_FREE    = 2'd1;
  localparam logic [1:0] CMD_QUERY   = 2'd2;
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam int GRAIN = 16;

  typedef struct packed {
    logic        reply_kind;
    logic        granted;
    logic [19:0] data_offset;
    logic [20:0] total_bytes;
    logic [20:0] used_bytes;
    logic [20:0] spare_bytes;
  } reply_t;

  typedef enum logic [17:0] {
    S_INIT = 18'b000000000000000001,
    S_IDLE = 18'b000000000000000010,
    S_ARD  = 18'b000000000000000100,
    S_ACK  = 18'b000000000000001000,
    S_SRD  = 18'b000000000000010000,
    S_SWR  = 18'b000000000000100000,
    S_SNEW = 18'b000000000001000000,
    S_SOWN = 18'b000000000010000000,
    S_FRD  = 18'b000000000100000000,
    S_FCK  = 18'b000000001000000000,
    S_NRD  = 18'b000000010000000000,
    S_NCK  = 18'b000000100000000000,
    S_DRD  = 18'b000001000000000000,
    S_DWR  = 18'b000010000000000000,
    S_PRD  = 18'b000100000000000000,
    S_PCK  = 18'b001000000000000000,
    S_WCUR = 18'b010000000000000000,
    S_OUT  = 18'b100000000000000000
  } state_t;

endpackage
`default_nettype wire

[rtl/core/ffba_table.sv]
// Block table memory: one write port, one registered read port.
`default_nettype none
module ffba_table #(
  parameter int DEPTH = 1024,
  parameter int IW    = 10,
  parameter int DW    = 43
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [IW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [IW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/core/ffba_ctrl.sv]
// Command sequencer: table walks, split inserts, merge removals.
`default_nettype none
module ffba_ctrl #(
  parameter int ARENA_BYTES  = 1048576,
  parameter int HEADER_BYTES = 16,
  parameter int MAX_BLOCKS   = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [1:0]         cmd,
  input  wire logic [20:0]        req_size,
  input  wire logic [19:0]        free_addr,
  input  wire logic               out_free,
  output logic                    idle,
  output logic                    rsp_valid,
  output ffba_pkg::reply_t        rsp
);

  localparam int LW = $clog2(ARENA_BYTES + 1);
  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int SW = ((LW > 22) ? LW : 22) + 2;
  localparam int DW = 2 * LW + 1;
  localparam logic [SW-1:0] HDR   = SW'(HEADER_BYTES);
  localparam logic [SW-1:0] GRN   = SW'(ffba_pkg::GRAIN);
  localparam logic [SW-1:0] GMSK  = SW'(ffba_pkg::GRAIN - 1);
  localparam logic [SW-1:0] ARENA = SW'(ARENA_BYTES);
  localparam logic [CW-1:0] MAXC  = CW'(MAX_BLOCKS);

  ffba_pkg::state_t state;
  logic [CW-1:0] count, idx, fi, k;
  logic [LW-1:0] used, cur_start, cur_len;
  logic [SW-1:0] need, addr;
  logic          drop_prev;

  logic          we;
  logic [IW-1:0] waddr, raddr;
  logic [DW-1:0] wdata, rdata;

  logic [LW-1:0] r_start, r_len;
  logic          r_busy;
  logic [SW-1:0] r_off, c_off, need_in, a_in, used_ext, spare_ext;

  ffba_table #(.DEPTH(MAX_BLOCKS), .IW(IW), .DW(DW)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign r_start   = rdata[LW-1:0];
  assign r_len     = rdata[2*LW-1:LW];
  assign r_busy    = rdata[2*LW];
  assign r_off     = SW'(r_start) + HDR;
  assign c_off     = SW'(cur_start) + HDR;
  assign used_ext  = SW'(used);
  assign spare_ext = ARENA - used_ext;
  assign a_in      = SW'(free_addr);
  assign idle      = (state == ffba_pkg::S_IDLE);
  assign rsp_valid = (state == ffba_pkg::S_OUT) && out_free;

  always_comb begin
    need_in = (SW'(req_size) + GMSK) & ~GMSK;
    if (need_in == '0) begin
      need_in = GRN;
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = '0;
    case (state)
      ffba_pkg::S_INIT: begin
        we    = 1'b1;
        wdata = {1'b0, LW'(ARENA - HDR), LW'(0)};
      end
      ffba_pkg::S_ARD, ffba_pkg::S_FRD: raddr = idx[IW-1:0];
      ffba_pkg::S_ACK: begin
        waddr = idx[IW-1:0];
        wdata = {1'b1, r_len, r_start};
        we    = !r_busy && SW'(r_len) >= need && SW'(r_len) < need + HDR + GRN;
      end
      ffba_pkg::S_SRD: raddr = IW'(k - 1'b1);
      ffba_pkg::S_SWR: begin
        we    = 1'b1;
        waddr = k[IW-1:0];
        wdata = rdata;
      end
      ffba_pkg::S_SNEW: begin
        we    = 1'b1;
        waddr = IW'(fi + 1'b1);
        wdata = {1'b0, LW'(SW'(cur_len) - need - HDR), LW'(c_off + need)};
      end
      ffba_pkg::S_SOWN: begin
        we    = 1'b1;
        waddr = fi[IW-1:0];
        wdata = {1'b1, LW'(need), cur_start};
      end
      ffba_pkg::S_NRD: raddr = IW'(fi + 1'b1);
      ffba_pkg::S_DRD: raddr = IW'(k + 1'b1);
      ffba_pkg::S_DWR: begin
        we    = 1'b1;
        waddr = k[IW-1:0];
        wdata = rdata;
      end
      ffba_pkg::S_PRD: raddr = IW'(fi - 1'b1);
      ffba_pkg::S_PCK: begin
        we    = !r_busy;
        waddr = IW'(fi - 1'b1);
        wdata = {1'b0, LW'(SW'(r_len) + HDR + SW'(cur_len)), r_start};
      end
      ffba_pkg::S_WCUR: begin
        we    = 1'b1;
        waddr = fi[IW-1:0];
        wdata = {1'b0, cur_len, cur_start};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffba_pkg::S_INIT;
      count <= CW'(1);
      used  <= '0;
    end else begin
      case (state)
        ffba_pkg::S_INIT: state <= ffba_pkg::S_IDLE;
        ffba_pkg::S_IDLE: begin
          if (start) begin
            idx  <= '0;
            need <= need_in;
            addr <= a_in;
            rsp  <= '0;
            case (cmd)
              ffba_pkg::CMD_ALLOC: state <= ffba_pkg::S_ARD;
              ffba_pkg::CMD_FREE: begin
                if (a_in >= HDR && (a_in - HDR) < ARENA) begin
                  state <= ffba_pkg::S_FRD;
                end
              end
              ffba_pkg::CMD_QUERY: begin
                rsp.reply_kind  <= ffba_pkg::KIND_QUERY;
                rsp.total_bytes <= ARENA[20:0];
                rsp.used_bytes  <= used_ext[20:0];
                rsp.spare_bytes <= spare_ext[20:0];
                state           <= ffba_pkg::S_OUT;
              end
              default: ;
            endcase
          end
        end
        ffba_pkg::S_ARD: begin
          if (idx == count) begin
            state <= ffba_pkg::S_OUT;
          end else begin
            state <= ffba_pkg::S_ACK;
          end
        end
        ffba_pkg::S_ACK: begin
          if (!r_busy && SW'(r_len) >= need) begin
            if (SW'(r_len) >= need + HDR + GRN) begin
              if (count == MAXC) begin
                state <= ffba_pkg::S_OUT;
              end else begin
                cur_start <= r_start;
                cur_len   <= r_len;
                fi        <= idx;
                k         <= count;
                state     <= (count > idx + 1'b1) ? ffba_pkg::S_SRD : ffba_pkg::S_SNEW;
              end
            end else begin
              used            <= used + r_len;
              rsp.granted     <= 1'b1;
              rsp.data_offset <= r_off[19:0];
              state           <= ffba_pkg::S_OUT;
            end
          end else begin
            idx   <= idx + 1'b1;
            state <= ffba_pkg::S_ARD;
          end
        end
        ffba_pkg::S_SRD: state <= ffba_pkg::S_SWR;
        ffba_pkg::S_SWR: begin
          k     <= k - 1'b1;
          state <= (k - 1'b1 > fi + 1'b1) ? ffba_pkg::S_SRD : ffba_pkg::S_SNEW;
        end
        ffba_pkg::S_SNEW: begin
          count <= count + 1'b1;
          state <= ffba_pkg::S_SOWN;
        end
        ffba_pkg::S_SOWN: begin
          used            <= used + LW'(need);
          rsp.granted     <= 1'b1;
          rsp.data_offset <= c_off[19:0];
          state           <= ffba_pkg::S_OUT;
        end
        ffba_pkg::S_FRD: begin
          state <= (idx == count) ? ffba_pkg::S_IDLE : ffba_pkg::S_FCK;
        end
        ffba_pkg::S_FCK: begin
          if (r_off == addr) begin
            fi        <= idx;
            cur_start <= r_start;
            cur_len   <= r_len;
            if (r_busy) begin
              used <= used - r_len;
            end
            state <= (idx + 1'b1 < count) ? ffba_pkg::S_NRD : ffba_pkg::S_PRD;
          end else begin
            idx   <= idx + 1'b1;
            state <= ffba_pkg::S_FRD;
          end
        end
        ffba_pkg::S_NRD: state <= ffba_pkg::S_NCK;
        ffba_pkg::S_NCK: begin
          if (!r_busy) begin
            cur_len   <= LW'(SW'(cur_len) + HDR + SW'(r_len));
            k         <= fi + 1'b1;
            drop_prev <= 1'b0;
            state     <= ffba_pkg::S_DRD;
          end else begin
            state <= ffba_pkg::S_PRD;
          end
        end
        ffba_pkg::S_DRD: begin
          if (k + 1'b1 < count) begin
            state <= ffba_pkg::S_DWR;
          end else begin
            count <= count - 1'b1;
            state <= drop_prev ? ffba_pkg::S_IDLE : ffba_pkg::S_PRD;
          end
        end
        ffba_pkg::S_DWR: begin
          k     <= k + 1'b1;
          state <= ffba_pkg::S_DRD;
        end
        ffba_pkg::S_PRD: begin
          state <= (fi == '0) ? ffba_pkg::S_WCUR : ffba_pkg::S_PCK;
        end
        ffba_pkg::S_PCK: begin
          if (!r_busy) begin
            k         <= fi;
            drop_prev <= 1'b1;
            state     <= ffba_pkg::S_DRD;
          end else begin
            state <= ffba_pkg::S_WCUR;
          end
        end
        ffba_pkg::S_WCUR: state <= ffba_pkg::S_IDLE;
        ffba_pkg::S_OUT: begin
          if (out_free) begin
            state <= ffba_pkg::S_IDLE;
          end
        end
        default: state <= ffba_pkg::S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/core/first_fit_block_allocator.sv]
// First-fit block allocator top level: stream ports and reply register.
//
// Keeps the arena's block table in one on-chip memory and serves one command
// at a time. After reset, an init state writes one free entry that spans the
// arena. An allocate walks the table, reading then checking each entry, until a
// fit; a split then moves every later entry up by one, each with a read and a
// write. A free walks the table the same way and each merge moves the later
// entries down by one, each with a read and a write. A query answers from a
// running total of used bytes. The table's single registered read port sets
// this step-by-step pace. A finished reply waits in the output register while
// the next command is taken.
`default_nettype none
module first_fit_block_allocator #(
  parameter int ARENA_BYTES  = 1048576,
  parameter int HEADER_BYTES = 16,
  parameter int MAX_BLOCKS   = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,  // cmd[1:0], req_size[22:2], free_addr[42:23]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [87:0]      m_tdata,  // granted, data_offset, total, used, spare bytes
  output logic             m_tuser   // reply_kind
);

  ffba_pkg::reply_t rsp, held;
  logic             rsp_valid, idle, out_free;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = idle;

  ffba_ctrl #(
    .ARENA_BYTES  (ARENA_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .MAX_BLOCKS   (MAX_BLOCKS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (s_tvalid && s_tready),
    .cmd       (s_tdata[1:0]),
    .req_size  (s_tdata[22:2]),
    .free_addr (s_tdata[42:23]),
    .out_free  (out_free),
    .idle      (idle),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (rsp_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_valid) begin
      held <= rsp;
    end
  end

  assign m_tuser = held.reply_kind;
  assign m_tdata = {4'd0, held.spare_bytes, held.used_bytes, held.total_bytes,
                    held.data_offset, held.granted};

endmodule
`default_nettype wire
